// ===== src/hmbs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmbs_pkg
// Types and constants shared by the height-field bilinear sampler.
// ---------------------------------------------------------------------------
package hmbs_pkg;

  // field widths
  localparam int unsigned CELL_W   = 8;
  localparam int unsigned HEIGHT_W = 32;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DIM_W    = 9;
  localparam int unsigned INV_W    = 26;
  localparam int unsigned PROD_W   = (POS_W - 1) + INV_W;   // 57-bit scaled position
  localparam int unsigned LERP_W   = (HEIGHT_W + 1) + (FRAC_W + 1);

  // stream word widths
  localparam int unsigned S_TDATA_W = 2 * CELL_W + HEIGHT_W + 2 * POS_W;  // 112
  localparam int unsigned M_TDATA_W = HEIGHT_W;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = INV_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_LENGTH = 2'd1,
    CFG_INV_SPACING = 2'd2
  } cfg_reg_t;

  localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0] GRID_LENGTH_RST = 9'd256;
  localparam logic [INV_W-1:0] INV_SPACING_RST = 26'd65536;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

endpackage

// ===== src/hmbs_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmbs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low.
// ---------------------------------------------------------------------------
module hmbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/heightmap_bilinear_sample_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heightmap_bilinear_sample_core
// Height grid store and bilinear sampler. Write words load one height;
// query words scale a Q16.16 position into grid units, clamp it, fetch the
// four corner heights from a 2x2 parity-banked grid memory and blend them.
// ---------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  s_*       in   tvalid/tready     tuser: req_type; tdata: cell_x, cell_z,
//                                   height_in, pos_x, pos_z
//  m_*       out  tvalid/tready     tuser: in_range; tdata: sample_height
//  cfg_*     in   cfg_we            cfg_index, cfg_data
//
//  One word enters per cycle when the output is not stalled. The rate is set
//  by the four grid banks, each read once per cycle at the memory stage
//  (stage 3 to 4). Every stage has its own valid bit and moves when the next
//  one is empty or moving, so bubbles close up under an output stall. Reset
//  clears the valid bits and sets the configuration registers to their
//  reset defaults; grid contents are undefined until written.
// ---------------------------------------------------------------------------
module heightmap_bilinear_sample_core #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] cell_x, [15:8] cell_z, [47:16] height_in, [79:48] pos_x, [111:80] pos_z
  input  logic [hmbs_pkg::S_TDATA_W-1:0]      s_tdata,
  // [0] req_type
  input  logic                                s_tuser,
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] sample_height
  output logic [hmbs_pkg::M_TDATA_W-1:0]      m_tdata,
  // [0] in_range
  output logic                                m_tuser,
  // configuration
  input  logic                                cfg_we,
  input  logic [hmbs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hmbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned XW     = ($clog2(MAX_DIM) > 1) ? $clog2(MAX_DIM) : 2;
  localparam int unsigned CB     = XW - 1;
  localparam int unsigned BANK_D = 1 << (2 * CB);
  localparam int unsigned IW     = (XW > hmbs_pkg::CELL_W) ? XW : hmbs_pkg::CELL_W;
  localparam int unsigned EW     = (XW + 1 > hmbs_pkg::DIM_W) ? XW + 1 : hmbs_pkg::DIM_W;
  localparam int unsigned HI_W   = hmbs_pkg::PROD_W - 32;

  typedef struct packed {
    logic [XW-1:0]               idx;
    logic [hmbs_pkg::FRAC_W-1:0] frac;
    logic                        in_grid;
  } axis_t;

  // -------------------------------------------------------------------------
  // configuration
  // -------------------------------------------------------------------------
  logic [hmbs_pkg::DIM_W-1:0] grid_width;
  logic [hmbs_pkg::DIM_W-1:0] grid_length;
  logic [hmbs_pkg::INV_W-1:0] inv_cell_spacing;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= hmbs_pkg::GRID_WIDTH_RST;
      grid_length      <= hmbs_pkg::GRID_LENGTH_RST;
      inv_cell_spacing <= hmbs_pkg::INV_SPACING_RST;
    end else if (cfg_we) begin
      unique case (hmbs_pkg::cfg_reg_t'(cfg_index))
        hmbs_pkg::CFG_GRID_WIDTH:  grid_width       <= cfg_data[hmbs_pkg::DIM_W-1:0];
        hmbs_pkg::CFG_GRID_LENGTH: grid_length      <= cfg_data[hmbs_pkg::DIM_W-1:0];
        hmbs_pkg::CFG_INV_SPACING: inv_cell_spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [XW-1:0] dim_last(input logic [hmbs_pkg::DIM_W-1:0] d);
    logic [EW-1:0] e;
    e = EW'(d);
    if (e < EW'(2)) begin
      e = EW'(2);
    end else if (e > EW'(MAX_DIM)) begin
      e = EW'(MAX_DIM);
    end
    return XW'(e - EW'(1));
  endfunction

  logic [XW-1:0]              w_last;
  logic [XW-1:0]              l_last;
  logic [hmbs_pkg::INV_W-1:0] inv_eff;

  assign w_last  = dim_last(grid_width);
  assign l_last  = dim_last(grid_length);
  assign inv_eff = (inv_cell_spacing == '0) ? hmbs_pkg::INV_W'(1) : inv_cell_spacing;

  // split a scaled position into base index and fraction, clamped to the grid
  function automatic axis_t clamp_axis(input logic [hmbs_pkg::PROD_W-1:0] p,
                                       input logic neg, input logic [XW-1:0] last);
    axis_t         r;
    logic [HI_W-1:0] hi;
    logic          gt;
    logic          eq;
    hi = p[hmbs_pkg::PROD_W-1:32];
    gt = hi > HI_W'(last);
    eq = hi == HI_W'(last);
    if (gt || (eq && (p[31:16] != '0))) begin
      r.idx  = last;
      r.frac = '0;
    end else begin
      r.idx  = hi[XW-1:0];
      r.frac = p[31:16];
    end
    r.in_grid = !neg && !gt && !(eq && (p[31:0] != '0));
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // stage enables: a stage moves when its successor is empty or moving
  // -------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic en1, en2, en3, en4, en5, en6, en7, en8, en9;

  assign en9 = !v9 || m_tready;
  assign en8 = !v8 || en9;
  assign en7 = !v7 || en8;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign s_tready = en1;

  // -------------------------------------------------------------------------
  // stage 1: input word
  // -------------------------------------------------------------------------
  logic                          req1;
  logic [hmbs_pkg::CELL_W-1:0]   cx1, cz1;
  logic [hmbs_pkg::HEIGHT_W-1:0] h1in;
  logic [hmbs_pkg::POS_W-1:0]    px1, pz1;

  always_ff @(posedge clk) begin
    if (en1) begin
      req1 <= s_tuser;
      cx1  <= s_tdata[7:0];
      cz1  <= s_tdata[15:8];
      h1in <= s_tdata[47:16];
      px1  <= s_tdata[79:48];
      pz1  <= s_tdata[111:80];
    end
  end

  // -------------------------------------------------------------------------
  // stage 2: scale positions into grid units
  // -------------------------------------------------------------------------
  logic                          req2;
  logic [hmbs_pkg::CELL_W-1:0]   cx2, cz2;
  logic [hmbs_pkg::HEIGHT_W-1:0] h2in;
  logic [hmbs_pkg::PROD_W-1:0]   prx2, prz2;
  logic                          nx2, nz2;

  always_ff @(posedge clk) begin
    if (en2) begin
      req2 <= req1;
      cx2  <= cx1;
      cz2  <= cz1;
      h2in <= h1in;
      nx2  <= px1[31];
      nz2  <= pz1[31];
      // a negative position lands on zero
      prx2 <= px1[31] ? '0 : px1[30:0] * inv_eff;
      prz2 <= pz1[31] ? '0 : pz1[30:0] * inv_eff;
    end
  end

  // -------------------------------------------------------------------------
  // stage 3: clamp, base cells and fractions
  // -------------------------------------------------------------------------
  logic                          req3;
  logic [hmbs_pkg::CELL_W-1:0]   cx3, cz3;
  logic [hmbs_pkg::HEIGHT_W-1:0] h3in;
  axis_t                         ax3, az3;

  always_ff @(posedge clk) begin
    if (en3) begin
      req3 <= req2;
      cx3  <= cx2;
      cz3  <= cz2;
      h3in <= h2in;
      ax3  <= clamp_axis(prx2, nx2, w_last);
      az3  <= clamp_axis(prz2, nz2, l_last);
    end
  end

  // -------------------------------------------------------------------------
  // grid memory: four banks by column and row parity, so the four corners
  // always fall in different banks
  // -------------------------------------------------------------------------
  logic [IW:0]    cxw, czw;
  logic [XW-1:0]  wx, wz;
  logic           wr_go;
  logic [1:0]     wbank;
  logic [2*CB-1:0] waddr;

  assign cxw   = (IW + 1)'(cx3);
  assign czw   = (IW + 1)'(cz3);
  assign wx    = cxw[XW-1:0];
  assign wz    = czw[XW-1:0];
  // coordinates at or past MAX_DIM drop the write
  assign wr_go = en4 && v3 && (hmbs_pkg::req_t'(req3) == hmbs_pkg::REQ_WRITE)
                 && (cxw < (IW + 1)'(MAX_DIM)) && (czw < (IW + 1)'(MAX_DIM));
  assign wbank = {wz[0], wx[0]};
  assign waddr = {wz[XW-1:1], wx[XW-1:1]};

  logic [hmbs_pkg::HEIGHT_W-1:0] bank_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BSEL = 2'(b);
    logic            xinc, zinc;
    logic [XW-1:0]   xs, zs;
    logic [2*CB-1:0] raddr;

    // pick whichever of base or base+1 has this bank's parity; on the last
    // sample the fraction is zero, so step back to the loaded cell before it
    assign xinc  = ax3.idx[0] ^ BSEL[0];
    assign zinc  = az3.idx[0] ^ BSEL[1];
    assign xs    = (xinc && (ax3.idx == w_last)) ? ax3.idx - XW'(1) : ax3.idx + XW'(xinc);
    assign zs    = (zinc && (az3.idx == l_last)) ? az3.idx - XW'(1) : az3.idx + XW'(zinc);
    assign raddr = {zs[XW-1:1], xs[XW-1:1]};

    hmbs_ram #(
      .WIDTH(hmbs_pkg::HEIGHT_W),
      .DEPTH(BANK_D)
    ) u_bank (
      .clk  (clk),
      .we   (wr_go && (wbank == BSEL)),
      .waddr(waddr),
      .wdata(h3in),
      .re   (en4),
      .raddr(raddr),
      .rdata(bank_q[b])
    );
  end

  // -------------------------------------------------------------------------
  // stage 4: corner heights (in the bank output registers)
  // -------------------------------------------------------------------------
  logic                        xp4, zp4, in4;
  logic [hmbs_pkg::FRAC_W-1:0] tx4, tz4;

  always_ff @(posedge clk) begin
    if (en4) begin
      xp4 <= ax3.idx[0];
      zp4 <= az3.idx[0];
      tx4 <= ax3.frac;
      tz4 <= az3.frac;
      in4 <= ax3.in_grid && az3.in_grid;
    end
  end

  logic signed [hmbs_pkg::HEIGHT_W-1:0] ca, cb, cc, cd;

  assign ca = $signed(bank_q[{zp4, xp4}]);
  assign cb = $signed(bank_q[{zp4, !xp4}]);
  assign cc = $signed(bank_q[{!zp4, xp4}]);
  assign cd = $signed(bank_q[{!zp4, !xp4}]);

  // -------------------------------------------------------------------------
  // stage 5: differences along x
  // -------------------------------------------------------------------------
  logic signed [hmbs_pkg::HEIGHT_W-1:0] a5, c5;
  logic signed [hmbs_pkg::HEIGHT_W:0]   dx0_5, dx1_5;
  logic [hmbs_pkg::FRAC_W-1:0]          tx5, tz5;
  logic                                 in5;

  always_ff @(posedge clk) begin
    if (en5) begin
      a5    <= ca;
      c5    <= cc;
      dx0_5 <= {cb[31], cb} - {ca[31], ca};
      dx1_5 <= {cd[31], cd} - {cc[31], cc};
      tx5   <= tx4;
      tz5   <= tz4;
      in5   <= in4;
    end
  end

  // -------------------------------------------------------------------------
  // stage 6: scale by the x fraction
  // -------------------------------------------------------------------------
  logic signed [hmbs_pkg::HEIGHT_W-1:0] a6, c6;
  logic signed [hmbs_pkg::LERP_W-1:0]   p0_6, p1_6;
  logic [hmbs_pkg::FRAC_W-1:0]          tz6;
  logic                                 in6;

  always_ff @(posedge clk) begin
    if (en6) begin
      a6   <= a5;
      c6   <= c5;
      p0_6 <= dx0_5 * $signed({1'b0, tx5});
      p1_6 <= dx1_5 * $signed({1'b0, tx5});
      tz6  <= tz5;
      in6  <= in5;
    end
  end

  // -------------------------------------------------------------------------
  // stage 7: rows blended along x; the sum always fits 32 bits, so the low
  // bits of the floored product are enough
  // -------------------------------------------------------------------------
  logic signed [hmbs_pkg::HEIGHT_W-1:0] h0_7, h1_7;
  logic [hmbs_pkg::FRAC_W-1:0]          tz7;
  logic                                 in7;

  always_ff @(posedge clk) begin
    if (en7) begin
      h0_7 <= a6 + $signed(p0_6[47:16]);
      h1_7 <= c6 + $signed(p1_6[47:16]);
      tz7  <= tz6;
      in7  <= in6;
    end
  end

  // -------------------------------------------------------------------------
  // stage 8: z difference scaled by the z fraction
  // -------------------------------------------------------------------------
  logic signed [hmbs_pkg::HEIGHT_W:0]   dz7;
  logic signed [hmbs_pkg::HEIGHT_W-1:0] h0_8;
  logic signed [hmbs_pkg::LERP_W-1:0]   pz8;
  logic                                 in8;

  assign dz7 = {h1_7[31], h1_7} - {h0_7[31], h0_7};

  always_ff @(posedge clk) begin
    if (en8) begin
      h0_8 <= h0_7;
      pz8  <= dz7 * $signed({1'b0, tz7});
      in8  <= in7;
    end
  end

  // -------------------------------------------------------------------------
  // stage 9: output register
  // -------------------------------------------------------------------------
  logic signed [hmbs_pkg::HEIGHT_W-1:0] h9;
  logic                                 in9;

  always_ff @(posedge clk) begin
    if (en9) begin
      h9  <= h0_8 + $signed(pz8[47:16]);
      in9 <= in8;
    end
  end

  // -------------------------------------------------------------------------
  // valid bits; write words leave after the memory stage
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3 && (hmbs_pkg::req_t'(req3) == hmbs_pkg::REQ_QUERY);
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
      if (en9) v9 <= v8;
    end
  end

  assign m_tvalid = v9;
  assign m_tdata  = h9;
  assign m_tuser  = in9;

endmodule
